>>> sv/kpd_pkg.sv
package kpd_pkg;

  localparam int NUM_COLS = 3;
  localparam int NUM_ROWS = 4;
  localparam int KEY_W    = 4;
  localparam int NUM_KEYS = NUM_COLS * NUM_ROWS;

  typedef logic [NUM_ROWS-1:0] rows_t;
  typedef rows_t [NUM_COLS-1:0] frame_t;
  typedef logic [KEY_W-1:0] key_t;

  // Status, kept across frames with an on or off hit and cleared by a frame with neither;
  // the rising-edge flag of the scheme never reaches an output and is not kept.
  typedef struct packed {
    logic detect;
    logic fall;
    logic key_on;
    logic key_off;
  } status_t;

  typedef struct packed {
    frame_t  last_frame;
    frame_t  settled;
    status_t status;
    logic    press_ok;
    key_t    press_code;
    logic    release_ok;
    key_t    release_code;
  } kpd_state_t;

  typedef struct packed {
    logic press_valid;
    key_t press_key;
    logic release_valid;
    key_t release_key;
  } kpd_result_t;

endpackage

>>> sv/keypad_debounce_edge_detector.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_rows_col0..2 (4 bits each)
// out_      output     out_valid / out_stall press_valid, press_key,
//                                            release_valid, release_key
//
// One scan frame per cycle while out_ is not stalled; a frame is held in the input
// register and its result then in the result register, which presents it on out_.
// The debounce and edge search is a single combinational pass between them.
// Synchronous active-low reset empties both stages and clears the history;
// both recorded key codes come out of reset as valid key 0.
// A stalled result holds; the input register keeps filling until both are full.
module keypad_debounce_edge_detector
  import kpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_rows_col0,
  input  logic [3:0] in_rows_col1,
  input  logic [3:0] in_rows_col2,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_press_valid,
  output logic [3:0] out_press_key,
  output logic       out_release_valid,
  output logic [3:0] out_release_key
);

  // Empty history, both key codes recorded as key 0.
  localparam kpd_state_t STATE_RESET = '{
    last_frame:   '0,
    settled:      '0,
    status:       '0,
    press_ok:     1'b1,
    press_code:   '0,
    release_ok:   1'b1,
    release_code: '0
  };

  logic        s1_valid_r;
  frame_t      frame_r;
  logic        out_valid_r;
  kpd_state_t  state_r;
  kpd_state_t  state_nxt;
  kpd_result_t result_r;
  kpd_result_t result_nxt;
  logic        out_adv;
  logic        s1_adv;

  // Advance the result stage when it is empty or being taken; the input
  // stage when it is empty or moving on.
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      frame_r[0] <= in_rows_col0;
      frame_r[1] <= in_rows_col1;
      frame_r[2] <= in_rows_col2;
    end
  end

  kpd_eval u_eval (
    .frame     (frame_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Commit history only when the frame moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_press_valid   = result_r.press_valid;
  assign out_press_key     = result_r.press_key;
  assign out_release_valid = result_r.release_valid;
  assign out_release_key   = result_r.release_key;

  a_fall_implies_detect: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.status.fall |-> state_r.status.detect)
    else $error("falling-edge flag without detect flag");

  a_status_needs_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.status.detect || state_r.status.fall) |->
      (state_r.status.key_on || state_r.status.key_off))
    else $error("detect flag set without an on or off mark");

  a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_press_valid) |-> (32'(out_press_key) < NUM_KEYS))
    else $error("press key code out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("frame in input register did not reach result register");

endmodule

>>> sv/kpd_eval.sv
module kpd_eval
  import kpd_pkg::*;
(
  input  frame_t      frame,
  input  kpd_state_t  state,
  output kpd_state_t  state_nxt,
  output kpd_result_t result
);

  frame_t  cur;
  frame_t  rise;
  frame_t  fall;
  frame_t  sel;
  logic    on_hit;
  logic    off_hit;
  logic    stop;
  logic    key_hit;
  key_t    key_code;
  status_t st;

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      // isolate lowest set row bit
      cur[c] = frame[c] & (~frame[c] + rows_t'(1));
    end
  end

  // First column that is stable and pressed, or stable, empty and formerly pressed.
  always_comb begin
    on_hit  = 1'b0;
    off_hit = 1'b0;
    stop    = 1'b0;
    for (int c = 0; c < NUM_COLS; c++) begin
      if (!stop && cur[c] == state.last_frame[c]) begin
        if (cur[c] != '0) begin
          on_hit = 1'b1;
          stop   = 1'b1;
        end else if (state.settled[c] != '0) begin
          off_hit = 1'b1;
          stop    = 1'b1;
        end
      end
    end
  end

  always_comb begin
    st         = state.status;
    st.key_on  = state.status.key_on | on_hit;
    st.key_off = state.status.key_off | off_hit;
    for (int c = 0; c < NUM_COLS; c++) begin
      rise[c] = cur[c] & ~state.settled[c];
      fall[c] = state.settled[c] & ~cur[c];
    end
    sel = st.key_on ? rise : fall;
  end

  // Column-major search, top row first within a column.
  always_comb begin
    key_hit  = 1'b0;
    key_code = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (!key_hit && sel[c][NUM_ROWS-1-r]) begin
          key_hit  = 1'b1;
          key_code = key_t'(c * NUM_ROWS + r);
        end
      end
    end
  end

  always_comb begin
    state_nxt = state;
    if (on_hit || off_hit) begin
      state_nxt.status = st;
      if (st.key_on) begin
        state_nxt.press_ok = key_hit;
        if (key_hit) begin
          state_nxt.press_code    = key_code;
          state_nxt.status.detect = 1'b1;
        end
      end else begin
        state_nxt.release_ok = key_hit;
        if (key_hit) begin
          state_nxt.release_code  = key_code;
          state_nxt.status.detect = 1'b1;
          state_nxt.status.fall   = 1'b1;
        end
      end
    end else begin
      state_nxt.status = '0;
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      if (cur[c] == state.last_frame[c]) begin
        state_nxt.settled[c] = cur[c];
      end
    end
    state_nxt.last_frame = cur;
  end

  always_comb begin
    result.press_valid   = state_nxt.status.detect & state_nxt.press_ok;
    result.press_key     = state_nxt.press_ok ? state_nxt.press_code : '0;
    result.release_valid = state_nxt.status.fall & state_nxt.release_ok;
    result.release_key   = state_nxt.release_ok ? state_nxt.release_code : '0;
  end

endmodule
